>>> rtl/core/xnalu_pkg.sv
`default_nettype none
package xnalu_pkg;

  typedef enum logic [3:0] {
    CMD_SUM  = 4'd0,
    CMD_DIST = 4'd1,
    CMD_MIN  = 4'd2,
    CMD_MAX  = 4'd3,
    CMD_EQ   = 4'd4,
    CMD_NEQ  = 4'd5,
    CMD_LEQ  = 4'd6,
    CMD_LTH  = 4'd7,
    CMD_GEQ  = 4'd8,
    CMD_GTH  = 4'd9,
    CMD_PROD = 4'd10,
    CMD_QUOT = 4'd11,
    CMD_REM  = 4'd12
  } cmd_e;

  typedef enum logic [1:0] {
    CL_FIN = 2'd0,
    CL_INF = 2'd1,
    CL_UND = 2'd2,
    CL_BAD = 2'd3
  } class_e;

  // how the back end produces the word
  typedef enum logic [1:0] {
    OP_DONE = 2'd0,
    OP_MUL  = 2'd1,
    OP_DIV  = 2'd2
  } op_e;

  localparam int unsigned CmdW   = 4;
  localparam int unsigned ClassW = 2;

endpackage
`default_nettype wire

>>> rtl/core/xnalu_front.sv
`default_nettype none
// classifies a word: settles special cases and cheap ops, tags mul/div work
module xnalu_front #(
  parameter int unsigned VW = 32
) (
  input  wire logic [3:0]    command_i,
  input  wire logic [VW-1:0] a_value_i,
  input  wire logic [1:0]    a_class_i,
  input  wire logic [VW-1:0] b_value_i,
  input  wire logic [1:0]    b_class_i,
  output xnalu_pkg::op_e     op_o,
  output logic               rem_o,
  output logic [VW-1:0]      a_o,
  output logic [VW-1:0]      b_o,
  output logic [VW-1:0]      r_value_o,
  output logic [1:0]         r_class_o,
  output logic               r_truth_o
);
  import xnalu_pkg::*;

  logic ainf, binf, aund, bund, afin, bfin, azero, bzero;
  logic lt, eq, gt;
  logic [VW:0] sum;

  always_comb begin
    aund  = (a_class_i == CL_UND) || (a_class_i == CL_BAD);
    bund  = (b_class_i == CL_UND) || (b_class_i == CL_BAD);
    ainf  = (a_class_i == CL_INF);
    binf  = (b_class_i == CL_INF);
    afin  = (a_class_i == CL_FIN);
    bfin  = (b_class_i == CL_FIN);
    azero = afin && (a_value_i == '0);
    bzero = bfin && (b_value_i == '0);
    eq    = (ainf && binf) || (afin && bfin && a_value_i == b_value_i);
    gt    = (ainf && bfin) || (afin && bfin && a_value_i > b_value_i);
    lt    = !eq && !gt;
    sum   = {1'b0, a_value_i} + {1'b0, b_value_i};
  end

  always_comb begin
    op_o      = OP_DONE;
    rem_o     = 1'b0;
    a_o       = a_value_i;
    b_o       = b_value_i;
    r_value_o = '0;
    r_class_o = CL_UND;
    r_truth_o = 1'b0;
    if (!aund && !bund) begin
      unique case (command_i)
        CMD_SUM: begin
          if (ainf || binf || sum[VW]) r_class_o = CL_INF;
          else begin
            r_class_o = CL_FIN;
            r_value_o = sum[VW-1:0];
          end
        end
        CMD_DIST: begin
          if (ainf || binf) r_class_o = CL_INF;
          else begin
            r_class_o = CL_FIN;
            r_value_o = gt ? a_value_i - b_value_i : b_value_i - a_value_i;
          end
        end
        CMD_MIN, CMD_MAX: begin
          if ((command_i == CMD_MIN) == !gt) begin
            r_class_o = ainf ? CL_INF : CL_FIN;
            r_value_o = ainf ? '0 : a_value_i;
          end else begin
            r_class_o = binf ? CL_INF : CL_FIN;
            r_value_o = binf ? '0 : b_value_i;
          end
        end
        CMD_EQ:  begin r_class_o = CL_FIN; r_truth_o = eq;  end
        CMD_NEQ: begin r_class_o = CL_FIN; r_truth_o = !eq; end
        CMD_LEQ: begin r_class_o = CL_FIN; r_truth_o = !gt; end
        CMD_LTH: begin r_class_o = CL_FIN; r_truth_o = lt;  end
        CMD_GEQ: begin r_class_o = CL_FIN; r_truth_o = !lt; end
        CMD_GTH: begin r_class_o = CL_FIN; r_truth_o = gt;  end
        CMD_PROD: begin
          if ((azero && binf) || (ainf && bzero)) r_class_o = CL_UND;
          else if (ainf || binf) r_class_o = CL_INF;
          else op_o = OP_MUL;
        end
        CMD_QUOT: begin
          if (bzero) r_class_o = azero ? CL_UND : CL_INF;
          else if (binf) r_class_o = ainf ? CL_UND : CL_FIN;
          else if (ainf) r_class_o = CL_INF;
          else op_o = OP_DIV;
        end
        CMD_REM: begin
          if (ainf || bzero) r_class_o = CL_UND;
          else if (binf) begin
            r_class_o = CL_FIN;
            r_value_o = a_value_i;
          end else begin
            op_o  = OP_DIV;
            rem_o = 1'b1;
          end
        end
        default: r_class_o = CL_UND;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/xnalu_mul.sv
`default_nettype none
// pipelined product: 16-bit digit of a per stage, saturating to infinity
module xnalu_mul #(
  parameter int unsigned VW = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire logic [VW-1:0] a_i,
  input  wire logic [VW-1:0] b_i,
  output logic               valid_o,
  output logic [VW-1:0]      p_o,
  output logic               ovf_o
);
  import xnalu_pkg::*;

  localparam int unsigned DW = 16;
  localparam int unsigned NS = (VW + DW - 1) / DW;
  localparam int unsigned AW = NS * DW;

  logic [NS-1:0]        vld_q;
  logic [AW-1:0]        a_q   [NS+1];
  logic [VW-1:0]        b_q   [NS+1];
  logic [VW-1:0]        acc_q [NS+1];
  logic                 ovf_q [NS+1];

  // vld_q[s] marks the data registered into stage s+1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else vld_q <= (vld_q << 1) | NS'(valid_i);
  end

  always_comb begin
    a_q[0]   = {{(AW-VW){1'b0}}, a_i};
    b_q[0]   = b_i;
    acc_q[0] = '0;
    ovf_q[0] = 1'b0;
  end

  for (genvar s = 0; s < NS; s++) begin : g_st
    logic [DW+VW-1:0] pp;
    logic [DW+2*VW:0] tot;
    always_comb begin
      pp  = a_q[s][s*DW +: DW] * b_q[s];
      tot = {{(DW+VW+1){1'b0}}, acc_q[s]} + ({{(VW+1){1'b0}}, pp} << (s*DW));
    end
    always_ff @(posedge clk_i) begin
      a_q[s+1]   <= a_q[s];
      b_q[s+1]   <= b_q[s];
      acc_q[s+1] <= tot[VW-1:0];
      ovf_q[s+1] <= ovf_q[s] || (tot[DW+2*VW:VW] != '0);
    end
  end

  assign valid_o = vld_q[NS-1];
  assign p_o     = acc_q[NS];
  assign ovf_o   = ovf_q[NS];

endmodule
`default_nettype wire

>>> rtl/core/xnalu_div.sv
`default_nettype none
// pipelined restoring divider, two quotient bits per stage
module xnalu_div #(
  parameter int unsigned VW = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire logic [VW-1:0] a_i,
  input  wire logic [VW-1:0] b_i,
  output logic               valid_o,
  output logic [VW-1:0]      q_o,
  output logic [VW-1:0]      r_o
);
  import xnalu_pkg::*;

  localparam int unsigned BPS = 2;
  localparam int unsigned NS  = (VW + BPS - 1) / BPS;
  localparam int unsigned QW  = NS * BPS;

  logic [NS-1:0] vld_q;
  logic [QW-1:0] q_q [NS+1];
  logic [VW-1:0] r_q [NS+1];
  logic [VW-1:0] d_q [NS+1];

  // vld_q[s] marks the data registered into stage s+1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else vld_q <= (vld_q << 1) | NS'(valid_i);
  end

  // q_q holds remaining dividend bits, shifted out at the top, with quotient bits shifted in at the bottom
  always_comb begin
    q_q[0] = {{(QW-VW){1'b0}}, a_i};
    r_q[0] = '0;
    d_q[0] = b_i;
  end

  for (genvar s = 0; s < NS; s++) begin : g_st
    logic [QW-1:0] q [BPS+1];
    logic [VW:0]   r [BPS+1];
    logic [VW:0]   t;
    always_comb begin
      q[0] = q_q[s];
      r[0] = {1'b0, r_q[s]};
      t    = '0;
      for (int k = 0; k < BPS; k++) begin
        t = {r[k][VW-1:0], q[k][QW-1]};
        if (t >= {1'b0, d_q[s]}) begin
          r[k+1] = t - {1'b0, d_q[s]};
          q[k+1] = {q[k][QW-2:0], 1'b1};
        end else begin
          r[k+1] = t;
          q[k+1] = {q[k][QW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      q_q[s+1] <= q[BPS];
      r_q[s+1] <= r[BPS][VW-1:0];
      d_q[s+1] <= d_q[s];
    end
  end

  assign valid_o = vld_q[NS-1];
  assign q_o     = q_q[NS][VW-1:0];
  assign r_o     = r_q[NS];

endmodule
`default_nettype wire

>>> rtl/core/extended_natural_alu_unit.sv
`default_nettype none
// extended natural alu: naturals plus infinity and undefined
// start with command_i and both operands (value plus class) issues a word;
// it is taken at a clock edge where start is high and busy is low.
// every word gives one result on r_value_o, r_class_o, r_truth_o for one
// cycle, marked by done_o; results leave in issue order.
// the front classifies each word in its issue cycle and writes it to a short
// queue; sum, dist, min, max, compares and all special cases finish there.
// the back end runs the queue head through a product pipeline
// (ceil(VALUE_WIDTH/16) stages) or a divider pipeline (ceil(VALUE_WIDTH/2)
// stages) or a one-stage bypass, then a result register.
// a mix of kinds is held in order. throughput is one word per cycle when
// kinds repeat; a change of kind holds the queue head until the other
// pipeline drains, and busy rises only while the queue is full.
// the receiver cannot stall. reset clears the queue and all valid flags.
module extended_natural_alu_unit #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [3:0]             command_i,
  input  wire logic [VALUE_WIDTH-1:0] a_value_i,
  input  wire logic [1:0]             a_class_i,
  input  wire logic [VALUE_WIDTH-1:0] b_value_i,
  input  wire logic [1:0]             b_class_i,
  output logic                        done_o,
  output logic [VALUE_WIDTH-1:0]      r_value_o,
  output logic [1:0]                  r_class_o,
  output logic                        r_truth_o
);
  import xnalu_pkg::*;

  localparam int unsigned VW   = VALUE_WIDTH;
  localparam int unsigned QD   = 4;
  localparam int unsigned PW   = 2;
  localparam int unsigned MLAT = (VW + 15) / 16;
  localparam int unsigned DLAT = (VW + 1) / 2;
  localparam int unsigned CW   = $clog2(DLAT + 2);

  typedef struct packed {
    op_e           op;
    logic          rem;
    logic [VW-1:0] a;
    logic [VW-1:0] b;
    logic [VW-1:0] value;
    logic [1:0]    cls;
    logic          truth;
  } entry_t;

  entry_t f_ent;
  op_e    f_op;

  xnalu_front #(.VW(VW)) u_front (
    .command_i (command_i),
    .a_value_i (a_value_i),
    .a_class_i (a_class_i),
    .b_value_i (b_value_i),
    .b_class_i (b_class_i),
    .op_o      (f_op),
    .rem_o     (f_ent.rem),
    .a_o       (f_ent.a),
    .b_o       (f_ent.b),
    .r_value_o (f_ent.value),
    .r_class_o (f_ent.cls),
    .r_truth_o (f_ent.truth)
  );
  assign f_ent.op = f_op;

  // queue
  entry_t        mem_q [QD];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;
  logic          push, pop;

  assign busy = (cnt_q == (PW+1)'(QD));
  assign push = start && !busy;

  // back end issue: one kind in flight at a time keeps results in order
  entry_t        head;
  op_e           kind_q;
  logic [CW-1:0] infl_q;
  logic          same_kind;

  assign head      = mem_q[rp_q];
  assign same_kind = (infl_q == '0) || (head.op == kind_q);
  assign pop       = (cnt_q != '0) && same_kind;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= f_ent;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  // multiply and divide pipelines
  logic          m_v, d_v;
  logic [VW-1:0] m_p, d_q, d_r;
  logic          m_ovf;

  xnalu_mul #(.VW(VW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pop && head.op == OP_MUL),
    .a_i     (head.a),
    .b_i     (head.b),
    .valid_o (m_v),
    .p_o     (m_p),
    .ovf_o   (m_ovf)
  );

  xnalu_div #(.VW(VW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pop && head.op == OP_DIV),
    .a_i     (head.a),
    .b_i     (head.b),
    .valid_o (d_v),
    .q_o     (d_q),
    .r_o     (d_r)
  );

  // remainder flag follows the divider
  logic [DLAT-1:0] rem_sr_q;
  always_ff @(posedge clk_i) begin
    rem_sr_q <= {rem_sr_q[DLAT-2:0], head.rem};
  end

  // bypass stage for settled words
  logic          by_v_q;
  entry_t        by_q;

  // in-flight count for the current kind
  logic          res_any;
  assign res_any = by_v_q || m_v || d_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      infl_q <= '0;
      kind_q <= OP_DONE;
      by_v_q <= 1'b0;
    end else begin
      by_v_q <= pop && head.op == OP_DONE;
      infl_q <= infl_q + CW'(pop) - CW'(res_any);
      if (pop) kind_q <= head.op;
    end
  end

  always_ff @(posedge clk_i) begin
    by_q <= head;
  end

  // result register
  logic          done_q;
  logic [VW-1:0] val_q;
  logic [1:0]    cls_q;
  logic          tru_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= res_any;
  end

  always_ff @(posedge clk_i) begin
    priority if (m_v) begin
      val_q <= m_ovf ? '0 : m_p;
      cls_q <= m_ovf ? CL_INF : CL_FIN;
      tru_q <= 1'b0;
    end else if (d_v) begin
      val_q <= rem_sr_q[DLAT-1] ? d_r : d_q;
      cls_q <= CL_FIN;
      tru_q <= 1'b0;
    end else begin
      val_q <= by_q.value;
      cls_q <= by_q.cls;
      tru_q <= by_q.truth;
    end
  end

  assign done_o    = done_q;
  assign r_value_o = val_q;
  assign r_class_o = cls_q;
  assign r_truth_o = tru_q;

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import xnalu_pkg::*;

  localparam int unsigned VW = 32;

  typedef struct packed {
    logic [3:0]    cmd;
    logic [VW-1:0] av;
    logic [1:0]    ac;
    logic [VW-1:0] bv;
    logic [1:0]    bc;
  } word_t;

  typedef struct packed {
    logic [VW-1:0] val;
    logic [1:0]    cls;
    logic          truth;
  } answer_t;

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  logic          busy;
  logic [3:0]    command_i;
  logic [VW-1:0] a_value_i;
  logic [1:0]    a_class_i;
  logic [VW-1:0] b_value_i;
  logic [1:0]    b_class_i;
  logic          done_o;
  logic [VW-1:0] r_value_o;
  logic [1:0]    r_class_o;
  logic          r_truth_o;

  word_t   pending_words[$];
  answer_t expected_answers[$];
  int      mismatches;
  int      checked;
  int      issued;
  int      gap_left;
  int      burst_left;

  extended_natural_alu_unit #(.VALUE_WIDTH(VW)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .command_i(command_i), .a_value_i(a_value_i), .a_class_i(a_class_i),
    .b_value_i(b_value_i), .b_class_i(b_class_i), .done_o(done_o),
    .r_value_o(r_value_o), .r_class_o(r_class_o), .r_truth_o(r_truth_o)
  );

  function automatic answer_t mk_answer(class_e c, logic [VW-1:0] v);
    answer_t r;
    r.cls = c;
    r.val = (c == CL_FIN) ? v : '0;
    r.truth = 1'b0;
    return r;
  endfunction

  function automatic answer_t predict_answer(word_t w);
    answer_t r;
    class_e ca;
    class_e cb;
    logic ainf;
    logic binf;
    logic azero;
    logic bzero;
    int ord;
    logic [VW:0] s;
    logic [2*VW-1:0] p;
    ca = (w.ac == CL_BAD) ? CL_UND : class_e'(w.ac);
    cb = (w.bc == CL_BAD) ? CL_UND : class_e'(w.bc);
    r = mk_answer(CL_UND, '0);
    ainf = (ca == CL_INF);
    binf = (cb == CL_INF);
    azero = (ca == CL_FIN) && (w.av == 0);
    bzero = (cb == CL_FIN) && (w.bv == 0);
    if (ainf && binf) ord = 0;
    else if (ainf) ord = 1;
    else if (binf) ord = -1;
    else if (w.av < w.bv) ord = -1;
    else if (w.av > w.bv) ord = 1;
    else ord = 0;
    if (ca != CL_UND && cb != CL_UND && w.cmd <= CMD_REM) begin
      case (cmd_e'(w.cmd))
        CMD_SUM: begin
          s = {1'b0, w.av} + {1'b0, w.bv};
          if (ainf || binf || s[VW]) r = mk_answer(CL_INF, '0);
          else r = mk_answer(CL_FIN, s[VW-1:0]);
        end
        CMD_DIST: begin
          if (ainf || binf) r = mk_answer(CL_INF, '0);
          else r = mk_answer(CL_FIN, (w.av >= w.bv) ? w.av - w.bv : w.bv - w.av);
        end
        CMD_MIN: r = (ord <= 0) ? mk_answer(ca, w.av) : mk_answer(cb, w.bv);
        CMD_MAX: r = (ord >= 0) ? mk_answer(ca, w.av) : mk_answer(cb, w.bv);
        CMD_PROD: begin
          p = w.av * w.bv;
          if ((azero && binf) || (ainf && bzero)) r = mk_answer(CL_UND, '0);
          else if (ainf || binf) r = mk_answer(CL_INF, '0);
          else if (p[2*VW-1:VW] != 0) r = mk_answer(CL_INF, '0);
          else r = mk_answer(CL_FIN, p[VW-1:0]);
        end
        CMD_QUOT: begin
          if (bzero) r = azero ? mk_answer(CL_UND, '0) : mk_answer(CL_INF, '0);
          else if (binf) r = ainf ? mk_answer(CL_UND, '0) : mk_answer(CL_FIN, '0);
          else if (ainf) r = mk_answer(CL_INF, '0);
          else r = mk_answer(CL_FIN, w.av / w.bv);
        end
        CMD_REM: begin
          if (ainf || bzero) r = mk_answer(CL_UND, '0);
          else if (binf) r = mk_answer(ca, w.av);
          else r = mk_answer(CL_FIN, w.av % w.bv);
        end
        default: begin
          r = mk_answer(CL_FIN, '0);
          case (cmd_e'(w.cmd))
            CMD_EQ:  r.truth = (ord == 0);
            CMD_NEQ: r.truth = (ord != 0);
            CMD_LEQ: r.truth = (ord <= 0);
            CMD_LTH: r.truth = (ord < 0);
            CMD_GEQ: r.truth = (ord >= 0);
            default: r.truth = (ord > 0);
          endcase
        end
      endcase
    end
    return r;
  endfunction

  function automatic logic [VW-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return VW'($urandom_range(0, 20));
      3: return {16'h0, 16'($urandom)};
      default: return VW'($urandom);
    endcase
  endfunction

  function automatic logic [1:0] rand_class();
    int k;
    k = $urandom_range(0, 19);
    if (k < 14) return CL_FIN;
    if (k < 17) return CL_INF;
    if (k < 19) return CL_UND;
    return CL_BAD;
  endfunction

  task automatic add_word(logic [3:0] c, logic [VW-1:0] av, logic [1:0] ac,
                          logic [VW-1:0] bv, logic [1:0] bc);
    word_t w;
    w = '{cmd: c, av: av, ac: ac, bv: bv, bc: bc};
    pending_words.push_back(w);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver: bursts with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      command_i <= '0;
      a_value_i <= '0;
      a_class_i <= '0;
      b_value_i <= '0;
      b_class_i <= '0;
      gap_left <= 0;
      burst_left <= 4;
      issued <= 0;
    end else begin
      if (start && !busy) begin
        expected_answers.push_back(predict_answer(
          '{cmd: command_i, av: a_value_i, ac: a_class_i, bv: b_value_i, bc: b_class_i}));
        issued <= issued + 1;
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          start <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_words.size() > 0) begin
          word_t w;
          w = pending_words.pop_front();
          start <= 1'b1;
          command_i <= w.cmd;
          a_value_i <= w.av;
          a_class_i <= w.ac;
          b_value_i <= w.bv;
          b_class_i <= w.bc;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_answers.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result word %h/%0d/%0d",
                                      r_value_o, r_class_o, r_truth_o);
      end else begin
        answer_t e;
        e = expected_answers.pop_front();
        checked <= checked + 1;
        if (e.val !== r_value_o || e.cls !== r_class_o || e.truth !== r_truth_o) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch word %0d: expected %h/%0d/%0d got %h/%0d/%0d",
                     checked, e.val, e.cls, e.truth, r_value_o, r_class_o, r_truth_o);
        end
      end
    end
  end

  initial begin
    int n;
    logic [3:0] c;
    mismatches = 0;
    checked = 0;
    // directed: every command on a finite zero and an infinity, then chosen edge cases
    for (int k = 0; k <= CMD_REM; k++) begin
      add_word(4'(k), '0, CL_FIN, '1, CL_INF);
    end
    add_word(CMD_PROD, 32'd0, CL_FIN, 32'd5, CL_INF);
    add_word(CMD_PROD, 32'd9, CL_INF, 32'd0, CL_FIN);
    add_word(CMD_PROD, '1, CL_FIN, 32'd2, CL_FIN);
    add_word(CMD_SUM, '1, CL_FIN, 32'd1, CL_FIN);
    add_word(CMD_QUOT, 32'd0, CL_FIN, 32'd0, CL_FIN);
    add_word(CMD_QUOT, 32'd7, CL_FIN, 32'd0, CL_FIN);
    add_word(CMD_QUOT, 32'd0, CL_INF, 32'd0, CL_INF);
    add_word(CMD_REM, 32'd3, CL_INF, 32'd4, CL_FIN);
    add_word(CMD_REM, 32'd3, CL_FIN, 32'd0, CL_FIN);
    add_word(CMD_DIST, 32'd0, CL_INF, 32'd0, CL_INF);
    add_word(CMD_GEQ, 32'd0, CL_INF, 32'd0, CL_INF);
    add_word(CMD_EQ, '1, CL_UND, '1, CL_FIN);
    add_word(4'd14, 32'd1, CL_FIN, 32'd1, CL_FIN);
    add_word(CMD_MIN, 32'd5, CL_FIN, 32'd5, CL_BAD);
    n = pending_words.size();
    // random; mostly legal commands with a few unknown codes
    for (int k = 0; k < 650; k++) begin
      c = ($urandom_range(0, 30) == 0) ? 4'($urandom_range(13, 15))
                                       : 4'($urandom_range(0, 12));
      add_word(c, rand_value(), rand_class(), rand_value(), rand_class());
    end
    n = pending_words.size() + n;
    wait (rst_ni);
    wait (pending_words.size() == 0 && !start);
    wait (expected_answers.size() == 0);
    repeat (40) @(posedge clk_i);
    $display("issued %0d words over all commands and operand classes, checked %0d",
             issued, checked);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
rtl/core/xnalu_pkg.sv
rtl/core/xnalu_front.sv
rtl/core/xnalu_mul.sv
rtl/core/xnalu_div.sv
rtl/core/extended_natural_alu_unit.sv
tb/tb_top.sv
